[src/y86df_pkg.sv]
// Shared types and constants for the Y86-64 decode and forwarding block.
// Holds instruction codes, register id codes and common widths; no dependencies.
package y86df_pkg;

  localparam int NUM_REGS_DEF = 15;
  localparam int ID_W         = 4;
  localparam int WORD_W       = 64;
  localparam int FWD_IDS_W    = 5 * ID_W;
  localparam int EX_INFO_W    = 9;

  typedef logic [ID_W-1:0]      reg_id_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [FWD_IDS_W-1:0] fwd_ids_t;
  typedef logic [EX_INFO_W-1:0] ex_info_t;

  localparam reg_id_t RID_NONE = 4'hF;
  localparam reg_id_t RID_SP   = 4'h4;

  typedef enum logic [3:0] {
    IC_HALT   = 4'd0,
    IC_NOP    = 4'd1,
    IC_RRMOVQ = 4'd2,
    IC_IRMOVQ = 4'd3,
    IC_RMMOVQ = 4'd4,
    IC_MRMOVQ = 4'd5,
    IC_OPQ    = 4'd6,
    IC_JXX    = 4'd7,
    IC_CALL   = 4'd8,
    IC_RET    = 4'd9,
    IC_PUSHQ  = 4'd10,
    IC_POPQ   = 4'd11,
    IC_IADDQ  = 4'd12
  } icode_t;

endpackage

[src/y86_decode_forwarding_unit.sv]
// Y86-64 pipeline decode stage: register id selection, register file and forwarding.
// Depends on y86df_pkg.
//
// Pipeline: decode register at acceptance, then result register when the output is free.
// Throughput: one transaction per cycle unless a stalled output holds the decode register;
// the register file is read at acceptance and written with the writeback values of the same
// transaction, so the next one sees them.
// Reset: synchronous; empties both stages and marks every register file entry as zero.
module y86_decode_forwarding_unit #(
  parameter int NUM_REGS = y86df_pkg::NUM_REGS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  y86df_pkg::reg_id_t  icode,
  input  y86df_pkg::reg_id_t  reg_a,
  input  y86df_pkg::reg_id_t  reg_b,
  input  y86df_pkg::word_t    next_pc,
  input  y86df_pkg::fwd_ids_t fwd_dest_ids,
  input  y86df_pkg::word_t    exec_result,
  input  y86df_pkg::word_t    mem_load_value,
  input  y86df_pkg::word_t    mem_alu_value,
  input  y86df_pkg::word_t    wb_load_value,
  input  y86df_pkg::word_t    wb_alu_value,
  input  y86df_pkg::ex_info_t ex_stage_info,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output y86df_pkg::reg_id_t  src_a,
  output y86df_pkg::reg_id_t  src_b,
  output y86df_pkg::reg_id_t  dest_e,
  output y86df_pkg::reg_id_t  dest_m,
  output y86df_pkg::word_t    operand_a,
  output y86df_pkg::word_t    operand_b,
  output logic                bubble_execute
);
  import y86df_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  // ------------------------------------------------------------------
  // Handshake control
  // ------------------------------------------------------------------
  logic accept;
  logic out_adv;
  logic s1_adv;
  logic s1_valid;

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_adv;
  // Hold the input only during reset or while the decode register is full and cannot drain.
  assign in_stall = rst || (s1_valid && !out_adv);
  assign accept   = in_valid && !in_stall;

  // ------------------------------------------------------------------
  // Register id selection from the incoming icode
  // ------------------------------------------------------------------
  reg_id_t dec_sa, dec_sb, dec_de, dec_dm;
  logic    dec_use_pc;

  always_comb begin
    dec_sa     = RID_NONE;
    dec_sb     = RID_NONE;
    dec_de     = RID_NONE;
    dec_dm     = RID_NONE;
    dec_use_pc = 1'b0;
    case (icode)
      IC_RRMOVQ: begin
        dec_sa = reg_a;
        dec_de = reg_b;
      end
      IC_IRMOVQ: begin
        dec_de = reg_b;
      end
      IC_RMMOVQ: begin
        dec_sa = reg_a;
        dec_sb = reg_b;
      end
      IC_MRMOVQ: begin
        dec_sb = reg_b;
        dec_dm = reg_a;
      end
      IC_OPQ: begin
        dec_sa = reg_a;
        dec_sb = reg_b;
        dec_de = reg_b;
      end
      IC_JXX: begin
        dec_use_pc = 1'b1;
      end
      IC_CALL: begin
        dec_sb     = RID_SP;
        dec_de     = RID_SP;
        dec_use_pc = 1'b1;
      end
      IC_RET: begin
        dec_sa = RID_SP;
        dec_sb = RID_SP;
        dec_de = RID_SP;
      end
      IC_PUSHQ: begin
        dec_sa = reg_a;
        dec_sb = RID_SP;
        dec_de = RID_SP;
      end
      IC_POPQ: begin
        dec_sa = RID_SP;
        dec_sb = RID_SP;
        dec_de = RID_SP;
        dec_dm = reg_a;
      end
      IC_IADDQ: begin
        dec_sb = reg_b;
        dec_de = reg_b;
      end
      default: begin
        // halt, nop and unused codes: no sources, no destinations
        dec_use_pc = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Register file: two banks, one per writeback port, plus a live-value
  // table that records which bank holds the newest copy of each register.
  // Both banks read at the acceptance edge, before this transaction's writes.
  // ------------------------------------------------------------------
  reg_id_t wb_dst_e, wb_dst_m;
  logic    we_e, we_m;
  logic    rd_a_ok, rd_b_ok;

  assign wb_dst_m = fwd_dest_ids[4*ID_W-1:3*ID_W];
  assign wb_dst_e = fwd_dest_ids[5*ID_W-1:4*ID_W];
  assign we_e     = accept && (int'(wb_dst_e) < NUM_REGS);
  assign we_m     = accept && (int'(wb_dst_m) < NUM_REGS);
  assign rd_a_ok  = int'(dec_sa) < NUM_REGS;
  assign rd_b_ok  = int'(dec_sb) < NUM_REGS;

  word_t bank_e [NUM_REGS];
  word_t bank_m [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [NUM_REGS-1:0] rf_lvt;   // 1: bank_m holds the newest value
  logic [NUM_REGS-1:0] rf_vld_next;
  logic [NUM_REGS-1:0] rf_lvt_next;

  word_t rd_e_a, rd_e_b, rd_m_a, rd_m_b;
  logic  rd_a_vld, rd_b_vld, rd_a_lvt, rd_b_lvt;

  always_ff @(posedge clk) begin
    if (we_e) begin
      bank_e[wb_dst_e[AW-1:0]] <= wb_alu_value;
    end
    if (accept && rd_a_ok) begin
      rd_e_a <= bank_e[dec_sa[AW-1:0]];
    end
    if (accept && rd_b_ok) begin
      rd_e_b <= bank_e[dec_sb[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_m) begin
      bank_m[wb_dst_m[AW-1:0]] <= wb_load_value;
    end
    if (accept && rd_a_ok) begin
      rd_m_a <= bank_m[dec_sa[AW-1:0]];
    end
    if (accept && rd_b_ok) begin
      rd_m_b <= bank_m[dec_sb[AW-1:0]];
    end
  end

  // Valid and live-value bits; the loaded value wins when both ports hit one register.
  always_comb begin
    rf_vld_next = rf_vld;
    rf_lvt_next = rf_lvt;
    if (we_e) begin
      rf_vld_next[wb_dst_e[AW-1:0]] = 1'b1;
      rf_lvt_next[wb_dst_e[AW-1:0]] = 1'b0;
    end
    if (we_m) begin
      rf_vld_next[wb_dst_m[AW-1:0]] = 1'b1;
      rf_lvt_next[wb_dst_m[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      rf_lvt <= '0;
    end else begin
      rf_vld <= rf_vld_next;
      rf_lvt <= rf_lvt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (rd_a_ok) begin
        rd_a_vld <= rf_vld[dec_sa[AW-1:0]];
        rd_a_lvt <= rf_lvt[dec_sa[AW-1:0]];
      end else begin
        rd_a_vld <= 1'b0;
        rd_a_lvt <= 1'b0;
      end
      if (rd_b_ok) begin
        rd_b_vld <= rf_vld[dec_sb[AW-1:0]];
        rd_b_lvt <= rf_lvt[dec_sb[AW-1:0]];
      end else begin
        rd_b_vld <= 1'b0;
        rd_b_lvt <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Decode register: ids and the later stages' values of one transaction
  // ------------------------------------------------------------------
  reg_id_t  s1_sa, s1_sb, s1_de, s1_dm;
  logic     s1_use_pc;
  word_t    s1_next_pc;
  fwd_ids_t s1_ids;
  word_t    s1_v_exec, s1_v_mem_ld, s1_v_mem_alu, s1_v_wb_ld, s1_v_wb_alu;
  ex_info_t s1_ex_info;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sa        <= dec_sa;
      s1_sb        <= dec_sb;
      s1_de        <= dec_de;
      s1_dm        <= dec_dm;
      s1_use_pc    <= dec_use_pc;
      s1_next_pc   <= next_pc;
      s1_ids       <= fwd_dest_ids;
      s1_v_exec    <= exec_result;
      s1_v_mem_ld  <= mem_load_value;
      s1_v_mem_alu <= mem_alu_value;
      s1_v_wb_ld   <= wb_load_value;
      s1_v_wb_alu  <= wb_alu_value;
      s1_ex_info   <= ex_stage_info;
    end
  end

  // ------------------------------------------------------------------
  // Forwarding: execute dstE, memory dstM, memory dstE, writeback dstM,
  // writeback dstE, then the register file; no source reads as zero.
  // ------------------------------------------------------------------
  function automatic word_t fwd_pick(reg_id_t src, fwd_ids_t ids, word_t v0, word_t v1,
                                     word_t v2, word_t v3, word_t v4, word_t rf_val);
    word_t r;
    if (src == RID_NONE)                    r = '0;
    else if (src == ids[1*ID_W-1:0])        r = v0;
    else if (src == ids[2*ID_W-1:1*ID_W])   r = v1;
    else if (src == ids[3*ID_W-1:2*ID_W])   r = v2;
    else if (src == ids[4*ID_W-1:3*ID_W])   r = v3;
    else if (src == ids[5*ID_W-1:4*ID_W])   r = v4;
    else                                    r = rf_val;
    return r;
  endfunction

  word_t rf_a, rf_b, op_a, op_b;
  logic  bubble;
  logic [3:0] e_icode;
  reg_id_t    e_dst_m;
  logic       e_cnd;

  assign rf_a = !rd_a_vld ? '0 : (rd_a_lvt ? rd_m_a : rd_e_a);
  assign rf_b = !rd_b_vld ? '0 : (rd_b_lvt ? rd_m_b : rd_e_b);

  assign op_a = s1_use_pc ? s1_next_pc :
                fwd_pick(s1_sa, s1_ids, s1_v_exec, s1_v_mem_ld, s1_v_mem_alu,
                         s1_v_wb_ld, s1_v_wb_alu, rf_a);
  assign op_b = fwd_pick(s1_sb, s1_ids, s1_v_exec, s1_v_mem_ld, s1_v_mem_alu,
                         s1_v_wb_ld, s1_v_wb_alu, rf_b);

  // Bubble on a not-taken jump in execute or a load whose dstM id equals either source id.
  assign e_icode = s1_ex_info[3:0];
  assign e_dst_m = s1_ex_info[7:4];
  assign e_cnd   = s1_ex_info[8];
  assign bubble  = ((e_icode == IC_JXX) && !e_cnd) ||
                   (((e_icode == IC_MRMOVQ) || (e_icode == IC_POPQ)) &&
                    ((e_dst_m == s1_sa) || (e_dst_m == s1_sb)));

  // ------------------------------------------------------------------
  // Stage valids and output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      src_a          <= s1_sa;
      src_b          <= s1_sb;
      dest_e         <= s1_de;
      dest_m         <= s1_dm;
      operand_a      <= op_a;
      operand_b      <= op_b;
      bubble_execute <= bubble;
    end
  end

endmodule

[src/y86df_checker.sv]
// Port-level checks for y86_decode_forwarding_unit, attached by bind.
// Depends on y86df_pkg.
module y86df_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input y86df_pkg::reg_id_t  src_a,
  input y86df_pkg::reg_id_t  src_b,
  input y86df_pkg::reg_id_t  dest_e,
  input y86df_pkg::reg_id_t  dest_m,
  input y86df_pkg::word_t    operand_a,
  input y86df_pkg::word_t    operand_b,
  input logic                bubble_execute
);
  import y86df_pkg::*;

  // Drop all results on reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(src_a) && $stable(src_b) &&
      $stable(dest_e) && $stable(dest_m) && $stable(operand_a) &&
      $stable(operand_b) && $stable(bubble_execute))
    else $error("stalled result changed");

  // No source B reads as zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (src_b == RID_NONE) |-> operand_b == '0)
    else $error("operand_b nonzero without source");

  // A result that appears on an empty output passed the decode register without a wait.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching transaction");

  // Stall the input only when the output is backed up.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

endmodule

bind y86_decode_forwarding_unit y86df_checker u_y86df_checker (.*);

[verif/y86_decode_forwarding_unit_checker.sv]
// Checker for the Y86-64 decode and forwarding block: watches both channels, predicts each
// result from its own register file copy and compares field by field. Depends on y86df_pkg.
`timescale 1ns / 100ps

module y86_decode_forwarding_unit_checker
  import y86df_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  reg_id_t  icode,
  input  reg_id_t  reg_a,
  input  reg_id_t  reg_b,
  input  word_t    next_pc,
  input  fwd_ids_t fwd_dest_ids,
  input  word_t    exec_result,
  input  word_t    mem_load_value,
  input  word_t    mem_alu_value,
  input  word_t    wb_load_value,
  input  word_t    wb_alu_value,
  input  ex_info_t ex_stage_info,
  input  logic     out_valid,
  input  logic     out_stall,
  input  reg_id_t  src_a,
  input  reg_id_t  src_b,
  input  reg_id_t  dest_e,
  input  reg_id_t  dest_m,
  input  word_t    operand_a,
  input  word_t    operand_b,
  input  logic     bubble_execute,
  output int       mismatch_count,
  output int       outstanding
);

  typedef struct packed {
    reg_id_t src_a;
    reg_id_t src_b;
    reg_id_t dest_e;
    reg_id_t dest_m;
    word_t   operand_a;
    word_t   operand_b;
    logic    bubble;
  } decode_out_t;

  // Stage values in forwarding priority order, index 0 first.
  typedef logic [4:0][WORD_W-1:0] stage_vals_t;

  word_t       arch_regs [NUM_REGS_DEF];
  decode_out_t decode_q [$];
  decode_out_t want;
  int          errs;

  function automatic word_t forward_operand(reg_id_t src, stage_vals_t vals);
    if (src == RID_NONE) return '0;
    for (int k = 0; k < 5; k++) begin
      if (src == fwd_dest_ids[4*k +: 4]) return vals[k];
    end
    return arch_regs[src];
  endfunction

  // Predict from the input payload as sampled at the accepting edge.
  function automatic decode_out_t predict_decode();
    decode_out_t r;
    stage_vals_t vals;
    reg_id_t     e_icode;
    reg_id_t     e_dstm;
    logic        e_load;
    vals = {wb_alu_value, wb_load_value, mem_alu_value, mem_load_value, exec_result};
    case (icode)
      IC_RRMOVQ, IC_RMMOVQ, IC_OPQ, IC_PUSHQ: r.src_a = reg_a;
      IC_POPQ, IC_RET:                        r.src_a = RID_SP;
      default:                                r.src_a = RID_NONE;
    endcase
    case (icode)
      IC_OPQ, IC_RMMOVQ, IC_MRMOVQ, IC_IADDQ: r.src_b = reg_b;
      IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:     r.src_b = RID_SP;
      default:                                r.src_b = RID_NONE;
    endcase
    case (icode)
      IC_RRMOVQ, IC_IRMOVQ, IC_OPQ, IC_IADDQ: r.dest_e = reg_b;
      IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:     r.dest_e = RID_SP;
      default:                                r.dest_e = RID_NONE;
    endcase
    r.dest_m = (icode == IC_MRMOVQ || icode == IC_POPQ) ? reg_a : RID_NONE;
    if (icode == IC_CALL || icode == IC_JXX) r.operand_a = next_pc;
    else r.operand_a = forward_operand(r.src_a, vals);
    r.operand_b = forward_operand(r.src_b, vals);
    e_icode = ex_stage_info[3:0];
    e_dstm  = ex_stage_info[7:4];
    e_load  = (e_icode == IC_MRMOVQ || e_icode == IC_POPQ);
    r.bubble = (e_icode == IC_JXX && !ex_stage_info[8]) ||
               (e_load && (e_dstm == r.src_a || e_dstm == r.src_b));
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decode_q.delete();
      foreach (arch_regs[i]) arch_regs[i] = '0;
      errs = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decode_q.size() == 0) begin
          errs++;
          $display("%0t: result with no transaction pending", $time);
        end else begin
          want = decode_q.pop_front();
          check_field("src_a", want.src_a, src_a);
          check_field("src_b", want.src_b, src_b);
          check_field("dest_e", want.dest_e, dest_e);
          check_field("dest_m", want.dest_m, dest_m);
          check_field("operand_a", want.operand_a, operand_a);
          check_field("operand_b", want.operand_b, operand_b);
          check_field("bubble_execute", want.bubble, bubble_execute);
        end
      end
      if (in_valid && !in_stall) begin
        decode_q.push_back(predict_decode());
        // writeback: dstE first, then dstM, so a load to the same register wins
        if (fwd_dest_ids[19:16] != RID_NONE) arch_regs[fwd_dest_ids[19:16]] = wb_alu_value;
        if (fwd_dest_ids[15:12] != RID_NONE) arch_regs[fwd_dest_ids[15:12]] = wb_load_value;
      end
    end
    mismatch_count <= errs;
    outstanding    <= decode_q.size();
  end

endmodule

[verif/y86_decode_forwarding_unit_tb.sv]
// Top of the testbench for the Y86-64 decode and forwarding block: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on y86df_pkg and the checker module.
`timescale 1ns / 100ps

module y86_decode_forwarding_unit_tb;
  import y86df_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AFTER   = 300;   // transactions sent before the long receiver hold
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 10;    // idle cycles after the checker's pending count reaches zero

  localparam fwd_ids_t NO_FWD = '1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_EVERY_THIRD, STALL_HEAVY} stall_mode_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  reg_id_t  icode;
  reg_id_t  reg_a;
  reg_id_t  reg_b;
  word_t    next_pc;
  fwd_ids_t fwd_dest_ids;
  word_t    exec_result;
  word_t    mem_load_value;
  word_t    mem_alu_value;
  word_t    wb_load_value;
  word_t    wb_alu_value;
  ex_info_t ex_stage_info;
  logic     out_valid;
  logic     out_stall;
  reg_id_t  src_a;
  reg_id_t  src_b;
  reg_id_t  dest_e;
  reg_id_t  dest_m;
  word_t    operand_a;
  word_t    operand_b;
  logic     bubble_execute;

  int mismatch_count;
  int outstanding;
  int sent_count;
  int burst_left;
  int cycles;

  y86_decode_forwarding_unit i_dut (
    .clk, .rst, .in_valid, .in_stall, .icode, .reg_a, .reg_b, .next_pc, .fwd_dest_ids,
    .exec_result, .mem_load_value, .mem_alu_value, .wb_load_value, .wb_alu_value,
    .ex_stage_info, .out_valid, .out_stall, .src_a, .src_b, .dest_e, .dest_m,
    .operand_a, .operand_b, .bubble_execute
  );

  y86_decode_forwarding_unit_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .icode, .reg_a, .reg_b, .next_pc, .fwd_dest_ids,
    .exec_result, .mem_load_value, .mem_alu_value, .wb_load_value, .wb_alu_value,
    .ex_stage_info, .out_valid, .out_stall, .src_a, .src_b, .dest_e, .dest_m,
    .operand_a, .operand_b, .bubble_execute, .mismatch_count, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Pack forwarding ids; the execute dstE sits in the low nibble.
  function automatic fwd_ids_t pack_ids(reg_id_t ex_e, reg_id_t mem_m, reg_id_t mem_e,
                                        reg_id_t wb_m, reg_id_t wb_e);
    return {wb_e, wb_m, mem_e, mem_m, ex_e};
  endfunction

  // Mostly full random words, with the all-zero and all-one corners and small values mixed in.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Bias ids toward the instruction's own registers so forwarding and hazards show up often.
  function automatic reg_id_t pick_id(reg_id_t ra, reg_id_t rb);
    case ($urandom_range(0, 9))
      0, 1:    return ra;
      2, 3:    return rb;
      4:       return RID_SP;
      5:       return RID_NONE;
      default: return reg_id_t'($urandom);
    endcase
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high into the next
  // transaction unless the burst ends, in which case drop it for a random gap.
  task automatic send_item(reg_id_t ic, reg_id_t ra, reg_id_t rb, word_t pc, fwd_ids_t ids,
                           word_t e_val, word_t m_load, word_t m_alu, word_t w_load,
                           word_t w_alu, ex_info_t info);
    int gap;
    icode          <= ic;
    reg_a          <= ra;
    reg_b          <= rb;
    next_pc        <= pc;
    fwd_dest_ids   <= ids;
    exec_result    <= e_val;
    mem_load_value <= m_load;
    mem_alu_value  <= m_alu;
    wb_load_value  <= w_load;
    wb_alu_value   <= w_alu;
    ex_stage_info  <= info;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_random_item(reg_id_t ic);
    reg_id_t  ra;
    reg_id_t  rb;
    reg_id_t  e_ic;
    fwd_ids_t ids;
    ex_info_t info;
    ra = ($urandom_range(0, 9) < 8) ? reg_id_t'($urandom_range(0, 14)) : reg_id_t'($urandom);
    rb = ($urandom_range(0, 9) < 8) ? reg_id_t'($urandom_range(0, 14)) : reg_id_t'($urandom);
    for (int k = 0; k < 5; k++) ids[4*k +: 4] = pick_id(ra, rb);
    // Load-use and mispredict triggers need the execute icode to be a load or a jump.
    case ($urandom_range(0, 5))
      0:       e_ic = IC_MRMOVQ;
      1:       e_ic = IC_POPQ;
      2:       e_ic = IC_JXX;
      default: e_ic = reg_id_t'($urandom);
    endcase
    info = {1'($urandom), pick_id(ra, rb), e_ic};
    send_item(ic, ra, rb, rand_word(), ids, rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), info);
  endtask

  // Receiver: stall on a pattern that changes per segment, plus one long hold that backs
  // the block up while the sender keeps offering transactions.
  initial begin : receiver
    stall_mode_t mode;
    int          seg_left;
    int          hold_left;
    int          phase;
    bit          held;
    out_stall <= 1'b0;
    mode      = STALL_NONE;
    seg_left  = 0;
    hold_left = 0;
    phase     = 0;
    held      = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && sent_count >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        mode     = stall_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(16, 160);
      end
      seg_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:        out_stall <= 1'b0;
          STALL_LIGHT:       out_stall <= ($urandom_range(0, 99) < 35);
          STALL_EVERY_THIRD: out_stall <= (phase % 3 == 0);
          default:           out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  initial begin : stimulus
    reg_id_t named_codes [5];
    reg_id_t ic;
    named_codes = '{IC_IRMOVQ, IC_RMMOVQ, IC_RET, IC_POPQ, IC_IADDQ};
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    icode          <= '0;
    reg_a          <= '0;
    reg_b          <= '0;
    next_pc        <= '0;
    fwd_dest_ids   <= '0;
    exec_result    <= '0;
    mem_load_value <= '0;
    mem_alu_value  <= '0;
    wb_load_value  <= '0;
    wb_alu_value   <= '0;
    ex_stage_info  <= '0;
    sent_count     = 0;
    burst_left     = $urandom_range(1, 40);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Writeback with dstE and dstM on the same register: the loaded value must land.
    send_item(IC_NOP, RID_NONE, RID_NONE, 64'h1,
              pack_ids(RID_NONE, RID_NONE, RID_NONE, 4'd3, 4'd3),
              64'h11, 64'h22, 64'h33, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
              {1'b1, RID_NONE, IC_NOP});
    // Separate writes, and a no-write id on neither side.
    send_item(IC_NOP, RID_NONE, RID_NONE, 64'h2,
              pack_ids(RID_NONE, RID_NONE, RID_NONE, 4'd14, 4'd5),
              64'h11, 64'h22, 64'h33, 64'hDEAD_BEEF_0000_000E, 64'hCAFE_F00D_0000_0005,
              {1'b1, RID_NONE, IC_NOP});
    // Plain register file reads.
    send_item(IC_RRMOVQ, 4'd3, 4'd14, 64'h3, NO_FWD, '1, '1, '1, '1, '1,
              {1'b1, RID_NONE, IC_NOP});
    send_item(IC_OPQ, 4'd5, 4'd14, 64'h4, NO_FWD, '1, '1, '1, '1, '1,
              {1'b1, RID_NONE, IC_NOP});
    // Walk the forwarding priority down from execute dstE to writeback dstE.
    send_item(IC_OPQ, 4'd3, 4'd3, 64'h5, pack_ids(4'd3, 4'd3, 4'd3, 4'd3, 4'd3),
              64'hE0, 64'hE1, 64'hE2, 64'hE3, 64'hE4, {1'b1, RID_NONE, IC_NOP});
    send_item(IC_OPQ, 4'd3, 4'd5, 64'h6, pack_ids(RID_NONE, 4'd3, 4'd3, 4'd3, 4'd3),
              64'hE0, 64'hE1, 64'hE2, 64'hE3, 64'hE4, {1'b1, RID_NONE, IC_NOP});
    send_item(IC_OPQ, 4'd3, 4'd5, 64'h7, pack_ids(RID_NONE, RID_NONE, 4'd3, 4'd3, 4'd3),
              64'hE0, 64'hE1, 64'hE2, 64'hE3, 64'hE4, {1'b1, RID_NONE, IC_NOP});
    send_item(IC_OPQ, 4'd3, 4'd5, 64'h8, pack_ids(RID_NONE, RID_NONE, RID_NONE, 4'd3, 4'd3),
              64'hE0, 64'hE1, 64'hE2, 64'hE3, 64'hE4, {1'b1, RID_NONE, IC_NOP});
    send_item(IC_OPQ, 4'd3, 4'd5, 64'h9,
              pack_ids(RID_NONE, RID_NONE, RID_NONE, RID_NONE, 4'd3),
              64'hE0, 64'hE1, 64'hE2, 64'hE3, 64'hE4, {1'b1, RID_NONE, IC_NOP});
    // Mispredicted jump in execute, and a taken one; valA is valP for jXX and call.
    send_item(IC_JXX, 4'd1, 4'd2, '1, NO_FWD, '0, '0, '0, '0, '0,
              {1'b0, RID_NONE, IC_JXX});
    send_item(IC_CALL, 4'd1, 4'd2, '0, NO_FWD, '0, '0, '0, '0, '0,
              {1'b1, RID_NONE, IC_JXX});
    // Load-use on src_b, on src_a, and on a source of none against a dstM of none.
    send_item(IC_MRMOVQ, 4'd2, 4'd6, 64'hA, NO_FWD, '0, '0, '0, '0, '0,
              {1'b0, 4'd6, IC_MRMOVQ});
    send_item(IC_PUSHQ, 4'd7, 4'd15, 64'hB, NO_FWD, '0, '0, '0, '0, '0,
              {1'b0, 4'd7, IC_POPQ});
    send_item(IC_HALT, 4'd0, 4'd0, 64'hC, NO_FWD, '0, '0, '0, '0, '0,
              {1'b0, RID_NONE, IC_MRMOVQ});
    // All-ones and all-zeros corners of every field.
    send_item(4'hF, 4'hF, 4'hF, '1, '1, '1, '1, '1, '1, '1, '1);
    send_item(IC_HALT, 4'd0, 4'd0, '0, '0, '0, '0, '0, '0, '0, '0);
    // Remaining instruction codes, then the unused ones.
    foreach (named_codes[i]) send_random_item(named_codes[i]);
    for (int c = IC_IADDQ + 1; c < 16; c++) send_random_item(reg_id_t'(c));

    // Random part: mostly real instructions, some unused codes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 8) ic = reg_id_t'($urandom_range(IC_RRMOVQ, IC_IADDQ));
      else ic = reg_id_t'($urandom);
      send_random_item(ic);
    end
    in_valid <= 1'b0;

    // Let the checker's pending count catch up, then drain.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
